// File: sv/ssq_pkg.sv
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared widths, codes and types for the stable sorted priority queue.
// ----------------------------------------------------------------------------
package ssq_pkg;

  // Fixed beat field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned KEY_W  = 8;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 5;

  // Parameter defaults
  localparam int unsigned DEF_CAPACITY = 16;
  localparam int unsigned DEF_KEY_BITS = 8;

  // Opcodes
  localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
  localparam logic [OP_W-1:0] OP_DISPATCH = 2'd1;
  localparam logic [OP_W-1:0] OP_MODIFY   = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_REMOVE,
    S_INS_START,
    S_INS,
    S_PUT_HEAD
  } state_t;

endpackage

// File: sv/ssq_ram.sv
// ----------------------------------------------------------------------------
// ssq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ssq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/stable_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded min-first queue of (id, key) entries held in one RAM in key order,
// stable on equal keys. Insert, dispatch head, and re-key at a position.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+-----------------------------------------------
//  in_      | start & !busy      | in_opcode, in_entry_id, in_key_value, in_position
//  out_     | out_valid (1 cyc)  | out_status, out_id, out_key, out_occupancy
//
//  Every accepted beat gives exactly one result beat. Entries move through
//  the single RAM one slot per cycle, so the time that busy stays high grows
//  with the occupancy before the beat; rejected and no-op beats never raise busy.
//  The result strobe is registered: it rises as busy falls, or in the cycle
//  after a rejected or no-op beat is taken.
//  rst_n (synchronous) empties the queue; RAM contents are not cleared.
//  The receiver cannot stall; busy holds off only new commands.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue #(
  parameter int unsigned CAPACITY = ssq_pkg::DEF_CAPACITY,
  parameter int unsigned KEY_BITS = ssq_pkg::DEF_KEY_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ssq_pkg::OP_W-1:0]    in_opcode,
  input  logic [ssq_pkg::ID_W-1:0]    in_entry_id,
  input  logic [ssq_pkg::KEY_W-1:0]   in_key_value,
  input  logic [ssq_pkg::POS_W-1:0]   in_position,
  output logic                        out_valid,
  output logic [ssq_pkg::STAT_W-1:0]  out_status,
  output logic [ssq_pkg::ID_W-1:0]    out_id,
  output logic [ssq_pkg::KEY_W-1:0]   out_key,
  output logic [ssq_pkg::OCC_W-1:0]   out_occupancy
);

  localparam int unsigned AW     = $clog2(CAPACITY);
  localparam int unsigned CW     = $clog2(CAPACITY + 1);
  localparam int unsigned KW     = (KEY_BITS < ssq_pkg::KEY_W) ? KEY_BITS : ssq_pkg::KEY_W;
  localparam int unsigned IDW    = ssq_pkg::ID_W;
  localparam int unsigned KOUT_W = ssq_pkg::KEY_W;
  localparam int unsigned OCC_W  = ssq_pkg::OCC_W;
  localparam int unsigned POS_W  = ssq_pkg::POS_W;
  localparam int unsigned CMP_W  = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned WORD_W = IDW + KW;

  // control and working registers
  ssq_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   ptr_r, ptr_nxt;
  logic [KW-1:0]   key_r, key_nxt;
  logic [IDW-1:0]  id_r, id_nxt;
  logic            is_mod_r, is_mod_nxt;

  // result registers
  logic                       out_valid_r, out_valid_nxt;
  logic [ssq_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [IDW-1:0]             out_id_r, out_id_nxt;
  logic [KW-1:0]              out_key_r, out_key_nxt;
  logic [CW-1:0]              out_count_r, out_count_nxt;

  // RAM port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic [KW-1:0]     rd_key;
  logic [IDW-1:0]    rd_id;

  // helpers
  logic [CW-1:0]     ptr_ext_inc;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  count_ext;
  logic              pos_bad;

  ssq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key      = ram_rdata[KW-1:0];
  assign rd_id       = ram_rdata[KW +: IDW];
  assign ptr_ext_inc = CW'(ptr_r) + CW'(1);
  assign pos_ext     = CMP_W'(in_position);
  assign count_ext   = CMP_W'(count_r);
  assign pos_bad     = (pos_ext == '0) || (pos_ext > count_ext);

  // state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssq_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    key_r        <= key_nxt;
    id_r         <= id_nxt;
    is_mod_r     <= is_mod_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_key_r    <= out_key_nxt;
    out_count_r  <= out_count_nxt;
  end

  // sequencer: next state, RAM accesses and result beat
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    key_nxt        = key_r;
    id_nxt         = id_r;
    is_mod_nxt     = is_mod_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ssq_pkg::ST_OK;
    out_id_nxt     = '0;
    out_key_nxt    = '0;
    out_count_nxt  = count_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = {id_r, key_r};
    ram_raddr      = '0;

    case (state_r)
      ssq_pkg::S_IDLE: begin
        if (start) begin
          case (in_opcode)
            ssq_pkg::OP_INSERT: begin
              if (count_r >= CW'(CAPACITY)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ssq_pkg::ST_FULL;
              end else begin
                key_nxt   = in_key_value[KW-1:0];
                id_nxt    = in_entry_id;
                state_nxt = ssq_pkg::S_INS_START;
              end
            end
            ssq_pkg::OP_DISPATCH: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ssq_pkg::ST_EMPTY;
              end else begin
                ram_raddr  = '0;
                ptr_nxt    = '0;
                is_mod_nxt = 1'b0;
                state_nxt  = ssq_pkg::S_HEAD;
              end
            end
            ssq_pkg::OP_MODIFY: begin
              if (pos_bad) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ssq_pkg::ST_BADPOS;
              end else begin
                ram_raddr  = AW'(pos_ext - CMP_W'(1));
                ptr_nxt    = AW'(pos_ext - CMP_W'(1));
                key_nxt    = in_key_value[KW-1:0];
                is_mod_nxt = 1'b1;
                state_nxt  = ssq_pkg::S_HEAD;
              end
            end
            default: begin
              // unused opcode: no change
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // entry to take out is on the read port
      ssq_pkg::S_HEAD: begin
        id_nxt = rd_id;
        if (!is_mod_r) begin
          key_nxt = rd_key;
        end
        if (ptr_ext_inc < count_r) begin
          ram_raddr = ptr_r + AW'(1);
          ptr_nxt   = ptr_r + AW'(1);
          state_nxt = ssq_pkg::S_REMOVE;
        end else begin
          count_nxt = count_r - CW'(1);
          if (is_mod_r) begin
            state_nxt = ssq_pkg::S_INS_START;
          end else begin
            out_valid_nxt = 1'b1;
            out_id_nxt    = rd_id;
            out_key_nxt   = rd_key;
            out_count_nxt = count_nxt;
            state_nxt     = ssq_pkg::S_IDLE;
          end
        end
      end

      // close the gap: slot ptr moves down to ptr-1
      ssq_pkg::S_REMOVE: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r - AW'(1);
        ram_wdata = ram_rdata;
        if (ptr_ext_inc < count_r) begin
          ram_raddr = ptr_r + AW'(1);
          ptr_nxt   = ptr_r + AW'(1);
        end else begin
          count_nxt = count_r - CW'(1);
          if (is_mod_r) begin
            state_nxt = ssq_pkg::S_INS_START;
          end else begin
            out_valid_nxt = 1'b1;
            out_id_nxt    = id_r;
            out_key_nxt   = key_r;
            out_count_nxt = count_nxt;
            state_nxt     = ssq_pkg::S_IDLE;
          end
        end
      end

      // begin the insert scan from the tail
      ssq_pkg::S_INS_START: begin
        if (count_r == '0) begin
          ram_we        = 1'b1;
          ram_waddr     = '0;
          count_nxt     = count_r + CW'(1);
          out_valid_nxt = 1'b1;
          out_count_nxt = count_nxt;
          state_nxt     = ssq_pkg::S_IDLE;
        end else begin
          ram_raddr = AW'(count_r - CW'(1));
          ptr_nxt   = AW'(count_r - CW'(1));
          state_nxt = ssq_pkg::S_INS;
        end
      end

      // larger keys move up one slot; stop at the first key <= new key
      ssq_pkg::S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r + AW'(1);
        if (rd_key > key_r) begin
          ram_wdata = ram_rdata;
          if (ptr_r == '0) begin
            state_nxt = ssq_pkg::S_PUT_HEAD;
          end else begin
            ram_raddr = ptr_r - AW'(1);
            ptr_nxt   = ptr_r - AW'(1);
          end
        end else begin
          count_nxt     = count_r + CW'(1);
          out_valid_nxt = 1'b1;
          out_count_nxt = count_nxt;
          state_nxt     = ssq_pkg::S_IDLE;
        end
      end

      // new entry becomes the head
      ssq_pkg::S_PUT_HEAD: begin
        ram_we        = 1'b1;
        ram_waddr     = '0;
        count_nxt     = count_r + CW'(1);
        out_valid_nxt = 1'b1;
        out_count_nxt = count_nxt;
        state_nxt     = ssq_pkg::S_IDLE;
      end

      default: begin
        state_nxt = ssq_pkg::S_IDLE;
      end
    endcase
  end

  assign busy          = (state_r != ssq_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_id        = out_id_r;
  assign out_key       = KOUT_W'(out_key_r);
  assign out_occupancy = OCC_W'(out_count_r);

endmodule
